// ----- sv/scrle_pkg.sv -----
// Package: shared types and constants of the signed-count run-length decoder.
`default_nettype none
package scrle_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned OffsetW = 17;
    localparam int unsigned CapW    = 16;
    localparam int unsigned OutOffW = 16;

    localparam logic [OffsetW-1:0] OffsetMax  = '1;
    localparam logic [CapW-1:0]    CapReset   = 16'd16000;
    localparam logic [8:0]         RepeatBase = 9'd257;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             block_end;
    } in_t;

    typedef struct packed {
        logic [ByteW-1:0]   out_value;
        logic [ByteW-1:0]   run_length;
        logic [OutOffW-1:0] out_offset;
        logic               overflow;
    } out_t;

    typedef logic [CapW-1:0] cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [ByteW-1:0]   literals_left;
        logic [ByteW-1:0]   repeat_count;
        logic [OffsetW-1:0] write_offset;
    } state_t;

endpackage
`default_nettype wire

// ----- sv/scrle_stream_if.sv -----
// Interface: valid/ready channel with a typed payload.
`default_nettype none
interface scrle_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/scrle_step.sv -----
// Decode step: next parse state and optional result for one compressed byte.
`default_nettype none
module scrle_step (
    input  scrle_pkg::state_t          state,
    input  scrle_pkg::in_t             item,
    input  logic [scrle_pkg::CapW-1:0] dest_capacity,
    output scrle_pkg::state_t          state_next,
    output logic                       produced,
    output scrle_pkg::out_t            result
);
    import scrle_pkg::*;

    logic [ByteW-1:0]   run;
    logic [OffsetW:0]   sum;
    logic [ByteW-1:0]   lit_dec;

    always_comb
    begin
        state_next = state;
        produced   = 1'b0;
        run        = 8'd1;
        lit_dec    = state.literals_left - 8'd1;

        unique case (state.mode)
            MODE_LITERAL:
            begin
                produced                 = 1'b1;
                run                      = 8'd1;
                state_next.literals_left = lit_dec;
                if (lit_dec == '0)
                begin
                    state_next.mode = MODE_HEADER;
                end
            end
            MODE_REPEAT:
            begin
                produced                = 1'b1;
                run                     = state.repeat_count;
                state_next.repeat_count = '0;
                state_next.mode         = MODE_HEADER;
            end
            default:
            begin
                // header byte: sign bit picks literal run or repeat
                if (!item.in_byte[ByteW-1])
                begin
                    state_next.literals_left = item.in_byte + 8'd1;
                    state_next.mode          = MODE_LITERAL;
                end
                else
                begin
                    state_next.repeat_count = ByteW'(RepeatBase - {1'b0, item.in_byte});
                    state_next.mode         = MODE_REPEAT;
                end
            end
        endcase

        sum = {1'b0, state.write_offset} + {{(OffsetW+1-ByteW){1'b0}}, run};

        result.out_value  = item.in_byte;
        result.run_length = run;
        result.out_offset = state.write_offset[OffsetW-1] ? '1
                                                          : state.write_offset[OutOffW-1:0];
        result.overflow   = sum > {{(OffsetW+1-CapW){1'b0}}, dest_capacity};

        if (produced)
        begin
            state_next.write_offset = sum[OffsetW] ? OffsetMax : sum[OffsetW-1:0];
        end

        if (item.block_end)
        begin
            state_next.mode          = MODE_HEADER;
            state_next.literals_left = '0;
            state_next.repeat_count  = '0;
            state_next.write_offset  = '0;
        end
    end
endmodule
`default_nettype wire

// ----- sv/scrle_skid.sv -----
// Output register with skid stage: decouples result delivery from input acceptance.
`default_nettype none
module scrle_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scrle_pkg::out_t push_data,
    output logic            can_push,
    output logic            out_valid,
    input  logic            out_ready,
    output scrle_pkg::out_t out_data
);
    import scrle_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    out_t main_reg;
    out_t skid_reg;
    logic out_fire;

    assign out_fire  = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || out_fire)
            begin
                // advance skid into main, or load the new request directly
                if (skid_valid_reg)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_fire)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/signed_count_rle_decoder.sv -----
// Top level: signed-count run-length decoder with capacity check.
`default_nettype none
// Takes one compressed byte per cycle on in_ch while in_ch.ready is high and returns at
// most one result per byte on out_ch: literal bytes come out with run length 1, a repeat
// value byte comes out once with its run length (2 to 129), header bytes give nothing.
// Each result is registered in a two-entry output buffer; the decode of each byte is a
// single registered step on the parse state, and the buffer lets bytes keep arriving at
// one per cycle as long as out_ch takes results. out_offset is the destination position
// of the first copy (saturating at 65535) and overflow flags a run ending past
// dest_capacity. A byte with block_end set returns the decoder to header mode and the
// offset to zero. dest_capacity resets to 16000; the user must write it through cfg
// only while the decoder is idle, which the block does not enforce; cfg is always ready.
module signed_count_rle_decoder (
    input  logic           clk,
    input  logic           rst_n,
    scrle_stream_if.sink   in_ch,
    scrle_stream_if.source out_ch,
    scrle_stream_if.sink   cfg
);
    import scrle_pkg::*;

    state_t          state_reg;
    state_t          state_next;
    logic [CapW-1:0] cap_reg;
    logic            produced;
    out_t            result;
    logic            can_push;
    logic            in_fire;

    assign in_ch.ready = can_push;
    assign cfg.ready   = 1'b1;
    assign in_fire     = in_ch.valid && can_push;

    scrle_step u_step (
        .state         (state_reg),
        .item          (in_ch.data),
        .dest_capacity (cap_reg),
        .state_next    (state_next),
        .produced      (produced),
        .result        (result)
    );

    scrle_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire && produced),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_HEADER;
            state_reg.literals_left <= '0;
            state_reg.repeat_count  <= '0;
            state_reg.write_offset  <= '0;
            cap_reg                 <= CapReset;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.run_length >= 8'd1 && out_ch.data.run_length <= 8'd129))
        else $error("result run length out of range");

    a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.data.block_end) |=>
            (state_reg.write_offset == '0 && state_reg.mode == MODE_HEADER))
        else $error("block end did not clear parse state");

    a_repeat_once: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && state_reg.mode == MODE_REPEAT) |=> state_reg.mode == MODE_HEADER)
        else $error("repeat value byte did not return to header mode");

    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && state_reg.mode == MODE_HEADER) |-> !produced)
        else $error("header byte produced a result");
endmodule
`default_nettype wire
